@@ hw/rtl/olist_pkg.sv @@
// olist_pkg: shared codes, widths and the cell command type of the ordered list engine.
// Depends on nothing; every other file of the block imports it.
package olist_pkg;

   // Default sizes, handed to the top level parameters
   localparam int DEF_CAPACITY   = 16;
   localparam int DEF_DATA_WIDTH = 32;

   // Fixed widths of the beat fields
   localparam int MODE_WIDTH   = 2;
   localparam int VALUE_WIDTH  = 32;
   localparam int STATUS_WIDTH = 3;

   // Operation codes on the request channel
   localparam logic [MODE_WIDTH-1:0] MODE_APPEND  = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_PREPEND = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_REMOVE  = 2'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_READ    = 2'd3;

   // Status codes on the response channel
   localparam logic [STATUS_WIDTH-1:0] STAT_ADDED     = 3'd0;
   localparam logic [STATUS_WIDTH-1:0] STAT_REMOVED   = 3'd1;
   localparam logic [STATUS_WIDTH-1:0] STAT_NOT_FOUND = 3'd2;
   localparam logic [STATUS_WIDTH-1:0] STAT_EMPTY     = 3'd3;
   localparam logic [STATUS_WIDTH-1:0] STAT_FULL      = 3'd4;
   localparam logic [STATUS_WIDTH-1:0] STAT_ENTRY     = 3'd5;

   // Cell operations
   localparam logic [2:0] CELL_HOLD   = 3'd0; // keep contents
   localparam logic [2:0] CELL_WRITE  = 3'd1; // selected cell loads the new value
   localparam logic [2:0] CELL_PUSH   = 3'd2; // every cell takes its left neighbour
   localparam logic [2:0] CELL_PULL   = 3'd3; // every cell takes its right neighbour
   localparam logic [2:0] CELL_ROTATE = 3'd4; // pull, selected cell takes the head

   typedef struct packed {
      logic [2:0] op;
      logic       hit;   // this cell is the one selected
   } cell_cmd_type;

endpackage

@@ hw/rtl/olist_if.sv @@
// olist_req_if and olist_rsp_if: valid/ready channels of the ordered list engine.
// Depends on olist_pkg for the field widths.
interface olist_req_if import olist_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic [MODE_WIDTH-1:0]         mode;
   logic signed [VALUE_WIDTH-1:0] value;

   modport source (output valid, output mode, output value, input ready);
   modport sink   (input valid, input mode, input value, output ready);
endinterface

interface olist_rsp_if import olist_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic [STATUS_WIDTH-1:0]       status;
   logic signed [VALUE_WIDTH-1:0] entry_value;
   logic                          last;

   modport source (output valid, output status, output entry_value, output last, input ready);
   modport sink   (input valid, input status, input entry_value, input last, output ready);
endinterface

@@ hw/rtl/olist_cell.sv @@
// olist_cell: one list slot, loading from its neighbours, the head or the new value.
// Depends on olist_pkg for the cell operation codes.
module olist_cell import olist_pkg::*; #(
   parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
   input  logic                  clock,
   input  cell_cmd_type          cmd,
   input  logic [DATA_WIDTH-1:0] load_data,
   input  logic [DATA_WIDTH-1:0] prev_data,
   input  logic [DATA_WIDTH-1:0] next_data,
   input  logic [DATA_WIDTH-1:0] head_data,
   output logic [DATA_WIDTH-1:0] data_out
);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;

   // next contents
   always_comb begin
      case (cmd.op)
         CELL_WRITE:  data_in = cmd.hit ? load_data : data_ff;
         CELL_PUSH:   data_in = prev_data;
         CELL_PULL:   data_in = next_data;
         CELL_ROTATE: data_in = cmd.hit ? head_data : next_data;
         default:     data_in = data_ff;
      endcase
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

@@ hw/rtl/ordered_list_engine.sv @@
// ordered_list_engine: bounded ordered list kept in a row of olist_cell slots.
// Depends on olist_pkg, olist_req_if / olist_rsp_if and olist_cell.
//
//   channel   dir  fields                          beat taken when
//   req_chan  in   mode, value                     valid && ready
//   rsp_chan  out  status, entry_value, last       valid && ready
//
// Append and prepend do not scan: the chain shifts or loads in parallel.
// Remove rotates the list once through cell 0, the first match being dropped
// on the way. Read out gives count beats, one per cycle while rsp_chan is
// ready, each rotating the list by one through cell 0.
// A new request is taken only with the engine idle and the response register
// free or being emptied. Reset clears the entry count and the control state;
// the cell contents are left as they are.
module ordered_list_engine import olist_pkg::*; #(
   parameter int CAPACITY   = DEF_CAPACITY,
   parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
   input logic         clock,
   input logic         reset,
   olist_req_if.sink   req_chan,
   olist_rsp_if.source rsp_chan
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int EXT_W = DATA_WIDTH + VALUE_WIDTH;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DUMP = 2'd2;

   // value field to stored width, zero extended or truncated
   function automatic logic [DATA_WIDTH-1:0] to_key(input logic [VALUE_WIDTH-1:0] v);
      logic [EXT_W-1:0] t;
      t = EXT_W'(v);
      return t[DATA_WIDTH-1:0];
   endfunction

   // stored width back to the value field
   function automatic logic [VALUE_WIDTH-1:0] to_value(input logic [DATA_WIDTH-1:0] d);
      logic [EXT_W-1:0] t;
      t = EXT_W'(d);
      return t[VALUE_WIDTH-1:0];
   endfunction

   logic [1:0]              state_ff,  state_in;
   logic [CNT_W-1:0]        count_ff,  count_in;
   logic [CNT_W-1:0]        steps_ff,  steps_in;
   logic                    found_ff,  found_in;
   logic [DATA_WIDTH-1:0]   key_ff,    key_in;
   logic                    rsp_valid_ff,  rsp_valid_in;
   logic [STATUS_WIDTH-1:0] rsp_status_ff, rsp_status_in;
   logic [VALUE_WIDTH-1:0]  rsp_value_ff,  rsp_value_in;
   logic                    rsp_last_ff,   rsp_last_in;

   logic                    take_rsp;
   logic                    accept;
   logic                    full;
   logic                    empty;
   logic                    drop;
   logic [DATA_WIDTH-1:0]   req_key;
   logic [DATA_WIDTH-1:0]   head;
   logic [CNT_W-1:0]        count_dec;
   logic [IDX_W-1:0]        tail_idx;
   logic [IDX_W-1:0]        sel;
   logic [2:0]              op;
   logic [DATA_WIDTH-1:0]   cell_data [CAPACITY];
   cell_cmd_type            cell_cmd  [CAPACITY];

   // handshake
   assign take_rsp       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && take_rsp;
   assign accept         = req_chan.valid && req_chan.ready;

   assign req_key   = to_key(req_chan.value);
   assign head      = cell_data[0];
   assign full      = (count_ff == CAP_CNT);
   assign empty     = (count_ff == '0);
   assign count_dec = count_ff - 1'b1;
   assign tail_idx  = count_dec[IDX_W-1:0];
   assign drop      = !found_ff && (head == key_ff);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      steps_in      = steps_ff;
      found_in      = found_ff;
      key_in        = key_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      op            = CELL_HOLD;
      sel           = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_value_in = to_value(req_key);
               rsp_last_in  = 1'b1;
               case (req_chan.mode)
                  MODE_APPEND, MODE_PREPEND: begin
                     rsp_valid_in = 1'b1;
                     if (full) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        rsp_status_in = STAT_ADDED;
                        count_in      = count_ff + 1'b1;
                        op  = (req_chan.mode == MODE_APPEND) ? CELL_WRITE : CELL_PUSH;
                        sel = count_ff[IDX_W-1:0];
                     end
                  end
                  MODE_REMOVE: begin
                     if (empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        state_in = ST_SCAN;
                        steps_in = count_ff;
                        found_in = 1'b0;
                        key_in   = req_key;
                     end
                  end
                  default: begin
                     if (empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_EMPTY;
                        rsp_value_in  = '0;
                     end else begin
                        state_in = ST_DUMP;
                        steps_in = count_ff;
                     end
                  end
               endcase
            end
         end

         // one head per cycle: drop the first match, otherwise wrap it to the tail
         ST_SCAN: begin
            steps_in = steps_ff - 1'b1;
            if (drop) begin
               op       = CELL_PULL;
               count_in = count_dec;
               found_in = 1'b1;
            end else begin
               op  = CELL_ROTATE;
               sel = tail_idx;
            end
            if (steps_ff == CNT_W'(1)) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = (found_ff || drop) ? STAT_REMOVED : STAT_NOT_FOUND;
               rsp_value_in  = to_value(key_ff);
               rsp_last_in   = 1'b1;
            end
         end

         // one beat per free response slot, list rotates back into place
         ST_DUMP: begin
            if (take_rsp) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_ENTRY;
               rsp_value_in  = to_value(head);
               rsp_last_in   = (steps_ff == CNT_W'(1));
               op            = CELL_ROTATE;
               sel           = tail_idx;
               steps_in      = steps_ff - 1'b1;
               if (steps_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         steps_ff     <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         steps_ff     <= steps_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.entry_value = rsp_value_ff;
   assign rsp_chan.last        = rsp_last_ff;

   // chain of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] prev_d;
      logic [DATA_WIDTH-1:0] next_d;

      assign cell_cmd[i].op  = op;
      assign cell_cmd[i].hit = (sel == IDX_W'(i));

      if (i == 0) begin : g_first
         assign prev_d = req_key;
      end else begin : g_mid
         assign prev_d = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_end
         assign next_d = cell_data[i];
      end else begin : g_inner
         assign next_d = cell_data[i+1];
      end

      olist_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock     (clock),
         .cmd       (cell_cmd[i]),
         .load_data (req_key),
         .prev_data (prev_d),
         .next_data (next_d),
         .head_data (head),
         .data_out  (cell_data[i])
      );
   end

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("entry count above capacity");

   a_scan_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !rsp_valid_ff)
      else $error("response pending during remove scan");

   a_dump_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DUMP) |=> (count_ff == $past(count_ff)))
      else $error("read out changed the entry count");

   a_prepend_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_chan.mode == MODE_PREPEND) && !full)
      |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("prepend did not grow the list");

endmodule

@@ dv/ordered_list_engine_test.sv @@
`timescale 1ns / 1ps
// ordered_list_engine_test: self-checking bench for the bounded ordered list engine.
// Depends on olist_pkg, olist_req_if / olist_rsp_if and ordered_list_engine.
module ordered_list_engine_test;
   import olist_pkg::*;

   localparam int CYCLE_LIMIT = 500_000;
   localparam int DRAIN_CYCLES = 2 * DEF_CAPACITY + 8;

   typedef struct packed {
      logic [STATUS_WIDTH-1:0]       status;
      logic signed [VALUE_WIDTH-1:0] entry_value;
      logic                          last;
   } list_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   olist_req_if req_chan ();
   olist_rsp_if rsp_chan ();

   ordered_list_engine DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Mirror of the list contents, head at index 0
   logic signed [VALUE_WIDTH-1:0] list_mirror[$];
   // Response beats still owed by the engine, oldest first
   list_beat_type owed_beats[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int fail_count = 0;
   int cycle_count = 0;
   int requests_sent = 0;
   int beats_checked = 0;
   int read_outs = 0;
   int full_hits = 0;
   int empty_hits = 0;

   // Clock, 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("ordered_list_engine regression: fail");
         $finish;
      end
   end

   // Response back-pressure, changed on the falling edge
   always @(negedge clock) begin
      rsp_chan.ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic void owe_beat(input logic [STATUS_WIDTH-1:0] status,
                                    input logic signed [VALUE_WIDTH-1:0] entry_value,
                                    input logic last);
      list_beat_type b;
      b.status = status;
      b.entry_value = entry_value;
      b.last = last;
      owed_beats.insert(owed_beats.size(), b);
   endfunction

   // Apply one accepted request to the mirror and queue the beats it owes
   function automatic void apply_list_request(input logic [MODE_WIDTH-1:0] mode,
                                              input logic signed [VALUE_WIDTH-1:0] value);
      int hit;
      int n;
      hit = -1;
      n = list_mirror.size();
      case (mode)
         MODE_APPEND, MODE_PREPEND: begin
            if (n >= DEF_CAPACITY) begin
               full_hits++;
               owe_beat(STAT_FULL, value, 1'b1);
            end else begin
               if (mode == MODE_APPEND) list_mirror.insert(list_mirror.size(), value);
               else list_mirror.push_front(value);
               owe_beat(STAT_ADDED, value, 1'b1);
            end
         end
         MODE_REMOVE: begin
            if (n == 0) begin
               empty_hits++;
               owe_beat(STAT_EMPTY, value, 1'b1);
            end else begin
               // first match wins
               for (int i = 0; i < n; i++) begin
                  if (hit < 0 && list_mirror[i] == value) hit = i;
               end
               if (hit < 0) begin
                  owe_beat(STAT_NOT_FOUND, value, 1'b1);
               end else begin
                  list_mirror.delete(hit);
                  owe_beat(STAT_REMOVED, value, 1'b1);
               end
            end
         end
         default: begin
            read_outs++;
            if (n == 0) begin
               empty_hits++;
               owe_beat(STAT_EMPTY, '0, 1'b1);
            end else begin
               for (int i = 0; i < n; i++) owe_beat(STAT_ENTRY, list_mirror[i], i == n - 1);
            end
         end
      endcase
   endfunction

   // Send one request beat, with a random gap in front of it
   task automatic send_list_request(input logic [MODE_WIDTH-1:0] mode,
                                    input logic signed [VALUE_WIDTH-1:0] value);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.mode  <= mode;
      req_chan.value <= value;
      do @(posedge clock); while (!req_chan.ready);
      apply_list_request(mode, value);
      requests_sent++;
   endtask

   // Check every accepted response beat against the oldest owed one
   always @(posedge clock) begin : check_rsp
      list_beat_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (owed_beats.size() == 0) begin
            $error("unexpected response beat: status %0d entry_value %0d last %0b",
                   rsp_chan.status, rsp_chan.entry_value, rsp_chan.last);
            fail_count++;
         end else begin
            want = owed_beats.pop_front();
            beats_checked++;
            if (rsp_chan.status !== want.status) begin
               $error("status mismatch: expected %0d, actual %0d",
                      want.status, rsp_chan.status);
               fail_count++;
            end
            if (rsp_chan.entry_value !== want.entry_value) begin
               $error("entry_value mismatch: expected %0d, actual %0d",
                      want.entry_value, rsp_chan.entry_value);
               fail_count++;
            end
            if (rsp_chan.last !== want.last) begin
               $error("last mismatch: expected %0b, actual %0b", want.last, rsp_chan.last);
               fail_count++;
            end
         end
      end
   end

   // Mostly small values so removes find matches, some corners, some full range
   function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
      logic signed [VALUE_WIDTH-1:0] v;
      int r;
      r = $urandom_range(99);
      if (r < 10) begin
         case ($urandom_range(3))
            0: v = 32'sh8000_0000;
            1: v = 32'sh7fff_ffff;
            2: v = '0;
            default: v = -32'sd1;
         endcase
      end else if (r < 60) begin
         v = $urandom_range(15);
         v = v - 32'sd8;
      end else begin
         v = $urandom;
      end
      return v;
   endfunction

   // Read out and remove on a list that has nothing in it
   task automatic test_empty_list();
      send_list_request(MODE_READ, 32'sh0bad_f00d);
      send_list_request(MODE_REMOVE, 32'sh1234_5678);
   endtask

   // Fill to capacity through both ends, then try to add past it
   task automatic test_fill_to_capacity();
      logic signed [VALUE_WIDTH-1:0] v;
      send_list_request(MODE_APPEND, 32'sh8000_0000);
      send_list_request(MODE_APPEND, 32'sh7fff_ffff);
      send_list_request(MODE_PREPEND, '0);
      send_list_request(MODE_PREPEND, -32'sd1);
      for (int k = 0; k < DEF_CAPACITY - 4; k++) begin
         case (k % 4)
            0: v = 32'sd7;
            1: v = 32'sh5555_5555;
            2: v = 32'shaaaa_aaaa;
            default: v = k * 1000;
         endcase
         send_list_request((k == 5) ? MODE_PREPEND : MODE_APPEND, v);
      end
      send_list_request(MODE_APPEND, 32'sd1);
      send_list_request(MODE_PREPEND, 32'sd2);
   endtask

   // First of duplicates, no match, removal next to the head and at the tail, then a read out
   task automatic test_remove_cases();
      send_list_request(MODE_REMOVE, 32'sd7);
      send_list_request(MODE_REMOVE, 32'sh1234_5678);
      send_list_request(MODE_REMOVE, -32'sd1);
      send_list_request(MODE_REMOVE, (DEF_CAPACITY - 5) * 1000);
      send_list_request(MODE_READ, '0);
   endtask

   // Random mix, swinging between filling and draining so both bounds are hit
   task automatic test_random_traffic(input int n_items);
      logic [MODE_WIDTH-1:0] mode;
      logic signed [VALUE_WIDTH-1:0] value;
      int add_pct;
      int remove_pct;
      int r;
      add_pct = 60;
      remove_pct = 25;
      for (int k = 0; k < n_items; k++) begin
         if (k % 16 == 15) begin
            add_pct = (add_pct == 60) ? 25 : 60;
            remove_pct = (remove_pct == 25) ? 60 : 25;
         end
         r = $urandom_range(99);
         if (r < add_pct) begin
            mode = $urandom_range(1) ? MODE_PREPEND : MODE_APPEND;
            value = pick_value();
         end else if (r < add_pct + remove_pct) begin
            mode = MODE_REMOVE;
            if (list_mirror.size() != 0 && $urandom_range(99) < 70)
               value = list_mirror[$urandom_range(list_mirror.size() - 1)];
            else
               value = pick_value();
         end else begin
            mode = MODE_READ;
            value = $urandom;
         end
         send_list_request(mode, value);
      end
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.mode  = MODE_APPEND;
      req_chan.value = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 27;
      recv_idle_pct = 81;
      test_empty_list();
      test_fill_to_capacity();
      test_remove_cases();
      test_random_traffic(52);

      send_idle_pct = 81;
      recv_idle_pct = 27;
      test_random_traffic(52);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(52);

      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (owed_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d requests (%0d read outs) and checked %0d response beats",
               requests_sent, read_outs, beats_checked);
      $display("adds refused on a full list: %0d, empty list replies: %0d",
               full_hits, empty_hits);
      if (fail_count == 0) begin
         $display("ordered_list_engine regression: pass");
      end else begin
         $display("ordered_list_engine regression: fail");
      end
      $finish;
   end

endmodule

@@ ordered_list_engine.f @@
hw/rtl/olist_pkg.sv
hw/rtl/olist_if.sv
hw/rtl/olist_cell.sv
hw/rtl/ordered_list_engine.sv
dv/ordered_list_engine_test.sv
